// ----- src/suffix_array_builder_macros.svh -----
// ----------------------------------------------------------------------------
// Suffix array builder assertion macros
// Shared concurrent assertion wrappers, clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef SUFFIX_ARRAY_BUILDER_MACROS_SVH
`define SUFFIX_ARRAY_BUILDER_MACROS_SVH

// checked only outside reset
`define SAB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked at every edge, reset included
`define SAB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- src/sab_pkg.sv -----
// ----------------------------------------------------------------------------
// Suffix array builder package
// Command/result word types and control structs shared by the block.
// ----------------------------------------------------------------------------
package sab_pkg;

   localparam int SYMBOL_W = 8;
   localparam int INDEX_W  = 10;
   localparam int START_W  = 10;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_READ   = 1'b1;

   typedef struct packed {
      logic                opcode;
      logic [SYMBOL_W-1:0] symbol;
      logic                is_last;
      logic [INDEX_W-1:0]  sorted_index;
   } req_type;

   typedef struct packed {
      logic [START_W-1:0] suffix_start;
      logic               error_flag;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic build;
      logic read;
   } core_cmd_type;

   typedef struct packed {
      logic build_done;
      logic read_done;
   } core_sts_type;

endpackage

// ----- src/suffix_array_builder.sv -----
// ----------------------------------------------------------------------------
// Suffix array builder
// Loads a byte string, builds its suffix array by prefix doubling, serves reads.
// ----------------------------------------------------------------------------
// Usage: a command word is taken on a clock edge with start high and busy low.
// An append (opcode 0) stores one symbol; is_last also starts the build. A read
// (opcode 1) returns the text position at sorted rank sorted_index.
// Every command yields one result word on rsp_item, valid for the single cycle
// that rsp_strobe is high; the receiver cannot stall it.
// A plain append or a failed read is answered in the next cycle; a good read
// first reads the order memory in ST_READ. The final append answers after the
// build, which runs on one sequencer with memory sweeps: seed ranks, then a
// counting sort (NB = max(MAX_LEN, MIN_BUCKETS) buckets, all cleared and
// scanned), and each of ceil(log2 n) doubling passes adds a sort plus rotate,
// re-rank and rank copy.
// busy stays high for the whole build or read; a new command is accepted in
// the cycle the result strobe shows.
// Reset clears length, overflow mark and the built flag; memories are not
// cleared and need no sweep.
// ----------------------------------------------------------------------------
module suffix_array_builder
   import sab_pkg::*;
#(
   parameter int MAX_LEN     = 1024,
   parameter int MIN_BUCKETS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   `include "suffix_array_builder_macros.svh"

   localparam int IW   = $clog2(MAX_LEN);
   localparam int LW   = $clog2(MAX_LEN + 1);
   localparam int CMPW = (LW > INDEX_W) ? LW : INDEX_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_BUILD = 3'b010,
      ST_READ  = 3'b100
   } top_state_type;

   top_state_type state_ff, state_in;
   logic [LW-1:0] len_ff, len_in;
   logic          ovf_ff, ovf_in, built_ff, built_in;
   logic          strobe_ff, strobe_in;
   rsp_type       rsp_ff, rsp_in;

   core_cmd_type  cmd;
   core_sts_type  sts;
   logic [IW-1:0] load_addr, read_addr, read_data;

   logic          accept, room, ovf0;
   logic [LW-1:0] len0, len1;

   assign accept    = start && !busy;
   assign len0      = built_ff ? '0 : len_ff;
   assign ovf0      = built_ff ? 1'b0 : ovf_ff;
   assign room      = (len0 < LW'(MAX_LEN));
   assign len1      = room ? (len0 + LW'(1)) : len0;
   assign load_addr = len0[IW-1:0];
   assign read_addr = IW'(req_item.sorted_index);

   always_comb begin
      state_in  = state_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      built_in  = built_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.opcode == OP_APPEND) begin
                  cmd.load = room;
                  len_in   = len1;
                  ovf_in   = ovf0 | !room;
                  built_in = 1'b0;
                  if (req_item.is_last) begin
                     cmd.build = 1'b1;
                     state_in  = ST_BUILD;
                  end else begin
                     strobe_in = 1'b1;
                     rsp_in    = '{suffix_start: '0, error_flag: ovf0 | !room};
                  end
               end else if (built_ff &&
                            (CMPW'(req_item.sorted_index) < CMPW'(len_ff))) begin
                  cmd.read = 1'b1;
                  state_in = ST_READ;
               end else begin
                  strobe_in = 1'b1;
                  rsp_in    = '{suffix_start: '0, error_flag: 1'b1};
               end
            end
         end
         ST_BUILD: begin
            if (sts.build_done) begin
               built_in  = 1'b1;
               strobe_in = 1'b1;
               rsp_in    = '{suffix_start: '0, error_flag: ovf_ff};
               state_in  = ST_IDLE;
            end
         end
         ST_READ: begin
            if (sts.read_done) begin
               strobe_in = 1'b1;
               rsp_in    = '{suffix_start: START_W'(read_data), error_flag: 1'b0};
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         len_ff    <= '0;
         ovf_ff    <= 1'b0;
         built_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         ovf_ff    <= ovf_in;
         built_ff  <= built_in;
         strobe_ff <= strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   sab_core #(
      .MAX_LEN     (MAX_LEN),
      .MIN_BUCKETS (MIN_BUCKETS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .load_addr (load_addr),
      .load_data (req_item.symbol),
      .build_len (len1),
      .read_addr (read_addr),
      .sts       (sts),
      .read_data (read_data)
   );

   // every accepted word is answered next cycle or the block goes busy
   `SAB_ASSERT(a_accept_answered, accept |=> (rsp_strobe || busy), "word neither answered nor busy")
   // leaving busy always delivers the pending word
   `SAB_ASSERT(a_busy_end_strobe, (!$past(reset) && $fell(busy)) |-> rsp_strobe, "busy ended without result")
   // error results carry a zero start
   `SAB_ASSERT(a_err_zero, (rsp_strobe && rsp_item.error_flag) |-> (rsp_item.suffix_start == '0), "error with nonzero start")
   // stored length never exceeds capacity
   `SAB_ASSERT(a_len_cap, len_ff <= LW'(MAX_LEN), "length beyond capacity")
   // no result word right out of reset
   `SAB_ASSERT_ALWAYS(a_reset_quiet, $past(reset) |-> !rsp_strobe, "result strobe after reset")

endmodule

// ----- src/sab_core.sv -----
// ----------------------------------------------------------------------------
// Suffix array builder core
// Text, order, rank and bucket memories with the prefix doubling sequencer.
// ----------------------------------------------------------------------------
module sab_core
   import sab_pkg::*;
#(
   parameter int MAX_LEN     = 1024,
   parameter int MIN_BUCKETS = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  core_cmd_type               cmd,
   input  logic [$clog2(MAX_LEN)-1:0] load_addr,
   input  logic [SYMBOL_W-1:0]        load_data,
   input  logic [$clog2(MAX_LEN+1)-1:0] build_len,
   input  logic [$clog2(MAX_LEN)-1:0] read_addr,
   output core_sts_type               sts,
   output logic [$clog2(MAX_LEN)-1:0] read_data
);

   localparam int IW  = $clog2(MAX_LEN);
   localparam int LW  = $clog2(MAX_LEN + 1);
   localparam int KW  = LW + 1;
   localparam int NB  = (MAX_LEN > MIN_BUCKETS) ? MAX_LEN : MIN_BUCKETS;
   localparam int RW  = $clog2(NB);
   localparam int CW  = LW;

   typedef enum logic [24:0] {
      S_IDLE    = 25'h0000001,
      S_INIT_RD = 25'h0000002,
      S_INIT_WR = 25'h0000004,
      S_CLR     = 25'h0000008,
      S_CNT_ORD = 25'h0000010,
      S_CNT_RNK = 25'h0000020,
      S_CNT_BKT = 25'h0000040,
      S_CNT_WR  = 25'h0000080,
      S_PFX_RD  = 25'h0000100,
      S_PFX_WR  = 25'h0000200,
      S_PLC_ORD = 25'h0000400,
      S_PLC_RNK = 25'h0000800,
      S_PLC_BKT = 25'h0001000,
      S_PLC_WR  = 25'h0002000,
      S_CPY_RD  = 25'h0004000,
      S_CPY_WR  = 25'h0008000,
      S_ROT_RD  = 25'h0010000,
      S_ROT_WR  = 25'h0020000,
      S_RR_ORD  = 25'h0040000,
      S_RR_RNK  = 25'h0080000,
      S_RR_PAIR = 25'h0100000,
      S_RR_WR   = 25'h0200000,
      S_NRC_RD  = 25'h0400000,
      S_NRC_WR  = 25'h0800000,
      S_RD_WAIT = 25'h1000000
   } seq_state_type;

   // memories
   logic [SYMBOL_W-1:0] text_mem    [MAX_LEN];
   logic [IW-1:0]       order_mem   [MAX_LEN];
   logic [RW-1:0]       rank_mem    [MAX_LEN];
   logic [RW-1:0]       nrank_mem   [MAX_LEN];
   logic [IW-1:0]       scratch_mem [MAX_LEN];
   logic [CW-1:0]       bucket_mem  [NB];

   logic [SYMBOL_W-1:0] text_q;
   logic [IW-1:0]       order_q, scratch_q;
   logic [RW-1:0]       rank_q0, rank_q1, nrank_q;
   logic [CW-1:0]       bucket_q;

   logic [IW-1:0] text_ra, order_ra, order_wa, order_wd, scratch_ra, scratch_wa, scratch_wd;
   logic [IW-1:0] rank_ra0, rank_ra1, rank_wa, nrank_ra, nrank_wa;
   logic [RW-1:0] rank_wd, nrank_wd, bucket_ra, bucket_wa;
   logic [CW-1:0] bucket_wd;
   logic          order_we, rank_we, nrank_we, scratch_we, bucket_we;

   seq_state_type state_ff, state_in;
   logic [LW-1:0] n_ff, n_in, i_ff, i_in;
   logic [RW-1:0] b_ff, b_in, r_ff, r_in, nra_ff, nra_in, ra_ff, ra_in, rb_ff, rb_in;
   logic [KW-1:0] k_ff, k_in;
   logic [CW-1:0] sum_ff, sum_in;
   logic [IW-1:0] e_ff, e_in, prev_ff, prev_in, cur_ff, cur_in;
   logic          pass_ff, pass_in;

   logic [IW-1:0] idx;
   logic          last_i, last_b, lt;
   logic [KW-1:0] n_ext, o_ext, rot_v, pa_s, pb_s, k_dbl;
   logic [RW-1:0] nr_val;

   always_ff @(posedge clock) begin
      if (cmd.load) text_mem[load_addr] <= load_data;
      text_q <= text_mem[text_ra];
   end

   always_ff @(posedge clock) begin
      if (order_we) order_mem[order_wa] <= order_wd;
      order_q <= order_mem[order_ra];
   end

   always_ff @(posedge clock) begin
      if (rank_we) rank_mem[rank_wa] <= rank_wd;
      rank_q0 <= rank_mem[rank_ra0];
      rank_q1 <= rank_mem[rank_ra1];
   end

   always_ff @(posedge clock) begin
      if (nrank_we) nrank_mem[nrank_wa] <= nrank_wd;
      nrank_q <= nrank_mem[nrank_ra];
   end

   always_ff @(posedge clock) begin
      if (scratch_we) scratch_mem[scratch_wa] <= scratch_wd;
      scratch_q <= scratch_mem[scratch_ra];
   end

   always_ff @(posedge clock) begin
      if (bucket_we) bucket_mem[bucket_wa] <= bucket_wd;
      bucket_q <= bucket_mem[bucket_ra];
   end

   assign idx    = i_ff[IW-1:0];
   assign last_i = (i_ff == n_ff - LW'(1));
   assign last_b = (b_ff == RW'(NB - 1));
   assign n_ext  = KW'(n_ff);
   assign o_ext  = KW'(order_q);
   // rotate back by k, modulo n
   assign rot_v  = (o_ext >= k_ff) ? (o_ext - k_ff) : (o_ext + n_ext - k_ff);
   assign pa_s   = KW'(prev_ff) + k_ff;
   assign pb_s   = KW'(cur_ff) + k_ff;
   assign k_dbl  = {k_ff[KW-2:0], 1'b0};
   assign lt     = (ra_ff != rb_ff) ? (ra_ff < rb_ff) : (rank_q0 < rank_q1);
   assign nr_val = nra_ff + RW'(lt);

   always_comb begin
      state_in = state_ff;
      n_in = n_ff; i_in = i_ff; b_in = b_ff; r_in = r_ff; k_in = k_ff;
      sum_in = sum_ff; e_in = e_ff; prev_in = prev_ff; cur_in = cur_ff;
      nra_in = nra_ff; ra_in = ra_ff; rb_in = rb_ff; pass_in = pass_ff;
      text_ra = idx; order_ra = idx; scratch_ra = idx; nrank_ra = idx;
      rank_ra0 = idx; rank_ra1 = idx; bucket_ra = RW'(0);
      order_we = 1'b0; order_wa = idx; order_wd = idx;
      rank_we = 1'b0; rank_wa = idx; rank_wd = RW'(text_q);
      nrank_we = 1'b0; nrank_wa = cur_ff; nrank_wd = nr_val;
      scratch_we = 1'b0; scratch_wa = bucket_q[IW-1:0]; scratch_wd = e_ff;
      bucket_we = 1'b0; bucket_wa = r_ff; bucket_wd = bucket_q + CW'(1);
      sts = '0;
      read_data = order_q;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.build) begin
               n_in = build_len; i_in = '0; k_in = KW'(1); pass_in = 1'b0;
               state_in = S_INIT_RD;
            end else if (cmd.read) begin
               order_ra = read_addr;
               state_in = S_RD_WAIT;
            end
         end
         S_RD_WAIT: begin
            sts.read_done = 1'b1;
            state_in = S_IDLE;
         end
         S_INIT_RD: state_in = S_INIT_WR;
         S_INIT_WR: begin
            rank_we = 1'b1; order_we = 1'b1;
            if (last_i) begin
               b_in = '0; state_in = S_CLR;
            end else begin
               i_in = i_ff + LW'(1); state_in = S_INIT_RD;
            end
         end
         S_CLR: begin
            bucket_we = 1'b1; bucket_wa = b_ff; bucket_wd = '0;
            if (last_b) begin
               i_in = '0; state_in = S_CNT_ORD;
            end else begin
               b_in = b_ff + RW'(1);
            end
         end
         S_CNT_ORD: state_in = S_CNT_RNK;
         S_CNT_RNK: begin
            rank_ra0 = order_q; state_in = S_CNT_BKT;
         end
         S_CNT_BKT: begin
            r_in = rank_q0; bucket_ra = rank_q0; state_in = S_CNT_WR;
         end
         S_CNT_WR: begin
            bucket_we = 1'b1;
            if (last_i) begin
               b_in = '0; sum_in = '0; state_in = S_PFX_RD;
            end else begin
               i_in = i_ff + LW'(1); state_in = S_CNT_ORD;
            end
         end
         S_PFX_RD: begin
            bucket_ra = b_ff; state_in = S_PFX_WR;
         end
         S_PFX_WR: begin
            bucket_we = 1'b1; bucket_wa = b_ff; bucket_wd = sum_ff;
            sum_in = sum_ff + bucket_q;
            if (last_b) begin
               i_in = '0; state_in = S_PLC_ORD;
            end else begin
               b_in = b_ff + RW'(1); state_in = S_PFX_RD;
            end
         end
         S_PLC_ORD: state_in = S_PLC_RNK;
         S_PLC_RNK: begin
            e_in = order_q; rank_ra0 = order_q; state_in = S_PLC_BKT;
         end
         S_PLC_BKT: begin
            r_in = rank_q0; bucket_ra = rank_q0; state_in = S_PLC_WR;
         end
         S_PLC_WR: begin
            scratch_we = 1'b1; bucket_we = 1'b1;
            if (last_i) begin
               i_in = '0; state_in = S_CPY_RD;
            end else begin
               i_in = i_ff + LW'(1); state_in = S_PLC_ORD;
            end
         end
         S_CPY_RD: state_in = S_CPY_WR;
         S_CPY_WR: begin
            order_we = 1'b1; order_wd = scratch_q;
            if (last_i) begin
               i_in = '0;
               priority if (pass_ff) state_in = S_RR_ORD;
               else if (k_ff < n_ext) state_in = S_ROT_RD;
               else begin
                  sts.build_done = 1'b1; state_in = S_IDLE;
               end
            end else begin
               i_in = i_ff + LW'(1); state_in = S_CPY_RD;
            end
         end
         S_ROT_RD: state_in = S_ROT_WR;
         S_ROT_WR: begin
            order_we = 1'b1; order_wd = rot_v[IW-1:0];
            if (last_i) begin
               i_in = '0; b_in = '0; pass_in = 1'b1; state_in = S_CLR;
            end else begin
               i_in = i_ff + LW'(1); state_in = S_ROT_RD;
            end
         end
         S_RR_ORD: state_in = S_RR_RNK;
         S_RR_RNK: begin
            if (i_ff == '0) begin
               // first sorted entry opens at rank zero
               nrank_we = 1'b1; nrank_wa = order_q; nrank_wd = '0;
               prev_in = order_q; nra_in = '0;
               i_in = i_ff + LW'(1); state_in = S_RR_ORD;
            end else begin
               rank_ra0 = prev_ff; rank_ra1 = order_q;
               cur_in = order_q; state_in = S_RR_PAIR;
            end
         end
         S_RR_PAIR: begin
            ra_in = rank_q0; rb_in = rank_q1;
            rank_ra0 = (pa_s >= n_ext) ? IW'(pa_s - n_ext) : IW'(pa_s);
            rank_ra1 = (pb_s >= n_ext) ? IW'(pb_s - n_ext) : IW'(pb_s);
            state_in = S_RR_WR;
         end
         S_RR_WR: begin
            nrank_we = 1'b1;
            nra_in = nr_val; prev_in = cur_ff;
            if (last_i) begin
               i_in = '0; state_in = S_NRC_RD;
            end else begin
               i_in = i_ff + LW'(1); state_in = S_RR_ORD;
            end
         end
         S_NRC_RD: state_in = S_NRC_WR;
         S_NRC_WR: begin
            rank_we = 1'b1; rank_wd = nrank_q;
            if (last_i) begin
               i_in = '0; k_in = k_dbl;
               if (k_dbl < n_ext) state_in = S_ROT_RD;
               else begin
                  sts.build_done = 1'b1; state_in = S_IDLE;
               end
            end else begin
               i_in = i_ff + LW'(1); state_in = S_NRC_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff <= n_in; i_ff <= i_in; b_ff <= b_in; r_ff <= r_in; k_ff <= k_in;
      sum_ff <= sum_in; e_ff <= e_in; prev_ff <= prev_in; cur_ff <= cur_in;
      nra_ff <= nra_in; ra_ff <= ra_in; rb_ff <= rb_in; pass_ff <= pass_in;
   end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Suffix array builder testbench
// Drives append and read command words, keeps a prefix-doubling predictor of
// the sorted cyclic shifts, and checks every result word in order.
// ----------------------------------------------------------------------------
module testbench;
   import sab_pkg::*;

   localparam int CAP      = 1024;
   localparam int NB_MIN   = 256;
   localparam int IDLE_MAX = 1000000;

   typedef struct {
      req_type word;
      bit      drain;
      int      max_gap;
   } pend_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   pend_type pending[$];
   rsp_type  expected_words[$];
   int       fails;
   int       wait_cnt;
   int       cur_max;
   int       gap;
   logic     acc;
   int       idle_cycles;
   pend_type nxt;
   rsp_type  got_exp;

   // predictor state
   logic [7:0]  txt_mem[CAP];
   int unsigned order_mem[CAP];
   int unsigned rank_mem[CAP];
   int unsigned new_rank_mem[CAP];
   int unsigned scratch_mem[CAP];
   int unsigned bucket_mem[CAP];
   int unsigned txt_len;
   bit          ovf_mark;
   bit          sa_ready;

   suffix_array_builder u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   always #6 clock = ~clock;

   // stable counting sort of the order by current rank
   function automatic void bucket_sort(int unsigned n);
      int unsigned nb, sum, c, r, e;
      nb = (n > NB_MIN) ? n : NB_MIN;
      if (nb > CAP) nb = CAP;
      sum = 0;
      for (int unsigned i = 0; i < nb; i++) bucket_mem[i] = 0;
      for (int unsigned i = 0; i < n; i++) begin
         r = rank_mem[order_mem[i] % CAP];
         if (r >= nb) r = nb - 1;
         bucket_mem[r]++;
      end
      for (int unsigned i = 0; i < nb; i++) begin
         c = bucket_mem[i];
         bucket_mem[i] = sum;
         sum += c;
      end
      for (int unsigned i = 0; i < n; i++) begin
         e = order_mem[i] % CAP;
         r = rank_mem[e];
         if (r >= nb) r = nb - 1;
         scratch_mem[bucket_mem[r] % CAP] = e;
         bucket_mem[r]++;
      end
      for (int unsigned i = 0; i < n; i++) order_mem[i] = scratch_mem[i];
   endfunction

   function automatic void build_order(int unsigned n);
      int unsigned v, a, b, pa, pb, lt;
      for (int unsigned i = 0; i < n; i++) begin
         rank_mem[i]  = 32'(txt_mem[i]);
         order_mem[i] = i;
      end
      bucket_sort(n);
      for (int unsigned k = 1; k < n; k <<= 1) begin
         for (int unsigned i = 0; i < n; i++) begin
            v = order_mem[i] + n - k;
            if (v >= n) v -= n;
            order_mem[i] = v;
         end
         bucket_sort(n);
         new_rank_mem[order_mem[0]] = 0;
         for (int unsigned i = 1; i < n; i++) begin
            a  = order_mem[i-1];
            b  = order_mem[i];
            pa = a + k;
            pb = b + k;
            if (pa >= n) pa -= n;
            if (pb >= n) pb -= n;
            if (rank_mem[a] != rank_mem[b]) lt = 32'(rank_mem[a] < rank_mem[b]);
            else lt = 32'(rank_mem[pa] < rank_mem[pb]);
            new_rank_mem[b] = new_rank_mem[a] + lt;
         end
         for (int unsigned i = 0; i < n; i++) rank_mem[i] = new_rank_mem[i];
      end
   endfunction

   function automatic rsp_type apply_word(req_type w);
      rsp_type r;
      r = '0;
      if (w.opcode == OP_APPEND) begin
         if (sa_ready) begin
            txt_len  = 0;
            ovf_mark = 0;
            sa_ready = 0;
         end
         if (txt_len < CAP) begin
            txt_mem[txt_len] = w.symbol;
            txt_len++;
         end else begin
            ovf_mark = 1;
         end
         if (w.is_last && txt_len > 0) begin
            build_order(txt_len);
            sa_ready = 1;
         end
         r.error_flag = ovf_mark;
      end else if (sa_ready && w.sorted_index < txt_len) begin
         r.suffix_start = START_W'(order_mem[w.sorted_index]);
      end else begin
         r.error_flag = 1;
      end
      return r;
   endfunction

   task automatic add(logic op, int sym, logic last, int idx, int mg, bit drain = 0);
      pend_type p;
      p.word.opcode       = op;
      p.word.symbol       = sym[7:0];
      p.word.is_last      = last;
      p.word.sorted_index = idx[9:0];
      p.drain             = drain;
      p.max_gap           = mg;
      pending = {pending, p};
   endtask

   // appends a text of n symbols; kind 0: random body + zero sentinel,
   // 1: repeated symbol, 2: fully random (no sentinel guarantee)
   task automatic add_text(int n, int kind, int mg);
      int sym;
      sym = $urandom_range(1, 255);
      for (int i = 0; i < n; i++) begin
         if (kind == 1) ;
         else if (kind == 2) sym = $urandom_range(0, 255);
         else if (i == n - 1) sym = 0;
         else sym = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                : $urandom_range(1, 255);
         add(OP_APPEND, sym, i == n - 1, $urandom_range(0, 1023), mg);
      end
   endtask

   task automatic add_reads(int n, int cnt, int mg, bit drain_first);
      int idx;
      for (int i = 0; i < cnt; i++) begin
         idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                           : $urandom_range(0, n - 1);
         add(OP_READ, $urandom_range(0, 255), 1'($urandom_range(0, 1)), idx, mg,
             drain_first && i == 0);
      end
   endtask

   // stimulus
   initial begin
      int n, mg, items;
      clock    = 0;
      reset    = 1;
      start    = 0;
      req_item = '0;
      fails    = 0;
      wait_cnt = 0;
      cur_max  = 0;
      txt_len  = 0;
      ovf_mark = 0;
      sa_ready = 0;

      // directed: read before any build, tiny texts, extreme symbols
      add(OP_READ, 0, 0, 0, 3);
      add(OP_READ, 255, 1, 1023, 3);
      add(OP_APPEND, 255, 1, 0, 3);
      add(OP_READ, 0, 0, 0, 3, 1);
      add(OP_READ, 0, 0, 1, 3);
      add(OP_APPEND, 98, 0, 1023, 0);
      add(OP_APPEND, 255, 0, 0, 0);
      add(OP_APPEND, 97, 0, 0, 0);
      add(OP_APPEND, 0, 1, 0, 0);
      for (int i = 0; i < 5; i++) add(OP_READ, 0, i[0], i, 2, i == 0);
      add(OP_READ, 0, 0, 1023, 2);
      add(OP_APPEND, 7, 0, 0, 2);
      add(OP_READ, 0, 0, 0, 2);
      add_text(4, 1, 1);
      add_reads(4, 4, 1, 1);

      // overflow: the full buffer plus two ignored appends
      for (int i = 0; i < CAP + 2; i++)
         add(OP_APPEND, (i == CAP - 1) ? 0 : $urandom_range(1, 255),
             i == CAP + 1, $urandom_range(0, 1023), (i < 64) ? 15 : 0);
      add(OP_READ, 0, 0, 1023, 4, 1);
      add(OP_READ, 0, 0, 512, 4);
      add(OP_READ, 0, 0, 0, 4);
      add_reads(CAP, 6, 4, 0);

      // random texts, mostly well formed with a sentinel
      items = 0;
      while (items < 450) begin
         n  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200)
                                           : $urandom_range(2, 24);
         mg = ($urandom_range(0, 3) == 0) ? 0 : 15;
         case ($urandom_range(0, 9))
            0:       add_text(n, 1, mg);
            1:       add_text(n, 2, mg);
            default: add_text(n, 0, mg);
         endcase
         add_reads(n, $urandom_range(1, 8), mg, $urandom_range(0, 5) == 0);
         if ($urandom_range(0, 7) == 0) begin
            // unfinished text: reads must fail
            add(OP_APPEND, $urandom_range(0, 255), 0, 0, mg);
            add_reads(1, 2, mg, 0);
            items += 3;
         end
         items += n + 5;
      end

      repeat (4) @(posedge clock);
      reset <= 0;
      do @(posedge clock);
      while (pending.size() != 0 || start || expected_words.size() != 0);
      repeat (8) @(posedge clock);
      if (fails == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start    <= 0;
         wait_cnt <= 0;
      end else begin
         acc = start && !busy;
         gap = wait_cnt;
         if (acc) begin
            expected_words = {expected_words, apply_word(req_item)};
            gap = (cur_max == 0 || $urandom_range(0, 4) == 0) ? 0
                                                             : $urandom_range(0, cur_max);
         end
         if (!start || acc) begin
            if (gap != 0) begin
               start    <= 0;
               wait_cnt <= gap - 1;
            end else if (pending.size() != 0 &&
                         !(pending[0].drain && expected_words.size() != 0)) begin
               nxt = pending.pop_front();
               start    <= 1;
               req_item <= nxt.word;
               cur_max  <= nxt.max_gap;
               wait_cnt <= 0;
            end else begin
               start    <= 0;
               wait_cnt <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected");
            fails++;
         end else begin
            got_exp = expected_words.pop_front();
            if (rsp_item.suffix_start !== got_exp.suffix_start) begin
               $error("suffix_start expected %0d got %0d",
                      got_exp.suffix_start, rsp_item.suffix_start);
               fails++;
            end
            if (rsp_item.error_flag !== got_exp.error_flag) begin
               $error("error_flag expected %0d got %0d",
                      got_exp.error_flag, rsp_item.error_flag);
               fails++;
            end
         end
      end
   end

   // watchdog: the full-size build runs long without a result word
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_MAX) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ----- suffix_array_builder.f -----
+incdir+src
src/sab_pkg.sv
src/sab_core.sv
src/suffix_array_builder.sv
tb/sv/testbench.sv
